### design/bbrm_pkg.sv
// shared types, constants and index function for the buddy release block
package bbrm_pkg;

    localparam int ORDERS   = 10;
    localparam int ORDER_W  = 4;
    localparam int BASE_W   = 10;
    localparam int MAP_BITS = 2 << ORDERS;
    localparam int MAP_AW   = ORDERS + 1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD      = 2'd1;
    localparam logic [1:0] ST_ALREADY  = 2'd2;

    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_QUERY   = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [ORDER_W-1:0] order;
        logic [BASE_W-1:0]  base;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [ORDER_W-1:0] final_order;
        logic [BASE_W-1:0]  final_base;
        logic               is_free;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_SELF_CHK,
        S_BUD_RD,
        S_BUD_CHK,
        S_SET,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic rd_self;
        logic rd_bud;
        logic wr_bud_clr;
        logic wr_set;
        logic set_free;
        logic set_dup;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic err;
        logic kind;
        logic rd_bit;
        logic at_top;
        logic clr_done;
    } t_dp_stat;

    // bitmaps for orders 0..ORDERS laid out back to back from order 0
    function automatic logic [MAP_AW-1:0] map_index(input logic [ORDER_W-1:0] k,
                                                    input logic [BASE_W-1:0]  b);
        logic [ORDER_W:0]  sh;
        logic [MAP_AW:0]   full;
        sh   = (ORDER_W+1)'(ORDERS) - {1'b0, k};
        full = (MAP_AW+1)'(MAP_BITS) - ((MAP_AW+1)'(2) << sh)
             + (MAP_AW+1)'(b >> k);
        return full[MAP_AW-1:0];
    endfunction

endpackage

### design/bbrm_ram.sv
// generic single port ram with registered read
module bbrm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/bbrm_datapath.sv
// item registers, bitmap addressing, bitmap ram and result register
module bbrm_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bbrm_pkg::t_in_item  i_item,
    input  bbrm_pkg::t_dp_cmd   i_cmd,
    output bbrm_pkg::t_dp_stat  o_stat,
    output bbrm_pkg::t_out_item o_item
);

    logic                          r_kind;
    logic                          r_err;
    logic                          r_dup;
    logic                          r_free;
    logic [bbrm_pkg::ORDER_W-1:0]  r_k;
    logic [bbrm_pkg::BASE_W-1:0]   r_cur;
    logic [bbrm_pkg::MAP_AW-1:0]   r_clr;
    bbrm_pkg::t_out_item           r_out;

    logic [15:0]                   align_mask;
    logic                          in_err;
    logic [bbrm_pkg::BASE_W-1:0]   k_bit;
    logic [bbrm_pkg::MAP_AW-1:0]   self_idx;
    logic [bbrm_pkg::MAP_AW-1:0]   bud_idx;
    logic                          ram_we;
    logic [bbrm_pkg::MAP_AW-1:0]   ram_addr;
    logic [0:0]                    ram_wdata;
    logic [0:0]                    ram_rdata;

    assign align_mask = (16'(1) << i_item.order) - 16'd1;
    assign in_err = (32'(i_item.order) > bbrm_pkg::ORDERS)
                 || ((i_item.base >> bbrm_pkg::ORDERS) != '0)
                 || ((16'(i_item.base) & align_mask) != 16'd0);

    assign k_bit    = bbrm_pkg::BASE_W'(1) << r_k;
    assign self_idx = bbrm_pkg::map_index(r_k, r_cur);
    assign bud_idx  = bbrm_pkg::map_index(r_k, r_cur ^ k_bit);

    always_comb begin
        ram_we    = i_cmd.clr_step | i_cmd.wr_bud_clr | i_cmd.wr_set;
        ram_wdata = i_cmd.wr_set;
        if (i_cmd.clr_step) begin
            ram_addr = r_clr;
        end else if (i_cmd.rd_bud || i_cmd.wr_bud_clr) begin
            ram_addr = bud_idx;
        end else begin
            ram_addr = self_idx;
        end
    end

    bbrm_ram #(
        .WIDTH(1),
        .DEPTH(bbrm_pkg::MAP_BITS)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // clear sweep pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_item.kind;
            r_err  <= in_err;
            r_k    <= i_item.order;
            r_cur  <= i_item.base;
            r_dup  <= 1'b0;
            r_free <= 1'b0;
        end else begin
            if (i_cmd.wr_bud_clr) begin
                r_cur <= r_cur & ~k_bit;
                r_k   <= r_k + 1'b1;
            end
            if (i_cmd.set_free) begin
                r_free <= ram_rdata[0];
            end
            if (i_cmd.set_dup) begin
                r_dup <= 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_out.status      <= r_err ? bbrm_pkg::ST_BAD
                               : (r_dup ? bbrm_pkg::ST_ALREADY : bbrm_pkg::ST_OK);
            r_out.final_order <= r_k;
            r_out.final_base  <= r_cur;
            r_out.is_free     <= r_free;
        end
    end

    assign o_stat.err      = r_err;
    assign o_stat.kind     = r_kind;
    assign o_stat.rd_bit   = ram_rdata[0];
    assign o_stat.at_top   = (32'(r_k) >= bbrm_pkg::ORDERS);
    assign o_stat.clr_done = (32'(r_clr) == bbrm_pkg::MAP_BITS - 1);
    assign o_item          = r_out;

endmodule

### design/bbrm_ctrl.sv
// sequencer for clear sweep, lookup and merge cascade
module bbrm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  bbrm_pkg::t_dp_stat i_stat,
    output bbrm_pkg::t_dp_cmd  o_cmd
);

    bbrm_pkg::t_state r_state;
    bbrm_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bbrm_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            bbrm_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = bbrm_pkg::S_IDLE;
                end
            end
            bbrm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bbrm_pkg::S_LOOKUP;
                end
            end
            bbrm_pkg::S_LOOKUP: begin
                if (i_stat.err) begin
                    n_state = bbrm_pkg::S_FIN;
                end else begin
                    o_cmd.rd_self = 1'b1;
                    n_state       = bbrm_pkg::S_SELF_CHK;
                end
            end
            bbrm_pkg::S_SELF_CHK: begin
                if (i_stat.kind == bbrm_pkg::KIND_QUERY) begin
                    o_cmd.set_free = 1'b1;
                    n_state        = bbrm_pkg::S_FIN;
                end else if (i_stat.rd_bit) begin
                    o_cmd.set_dup = 1'b1;
                    n_state       = bbrm_pkg::S_FIN;
                end else begin
                    n_state = bbrm_pkg::S_BUD_RD;
                end
            end
            bbrm_pkg::S_BUD_RD: begin
                if (i_stat.at_top) begin
                    n_state = bbrm_pkg::S_SET;
                end else begin
                    o_cmd.rd_bud = 1'b1;
                    n_state      = bbrm_pkg::S_BUD_CHK;
                end
            end
            bbrm_pkg::S_BUD_CHK: begin
                if (i_stat.rd_bit) begin
                    o_cmd.wr_bud_clr = 1'b1;
                    n_state          = bbrm_pkg::S_BUD_RD;
                end else begin
                    n_state = bbrm_pkg::S_SET;
                end
            end
            bbrm_pkg::S_SET: begin
                o_cmd.wr_set = 1'b1;
                n_state      = bbrm_pkg::S_FIN;
            end
            bbrm_pkg::S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bbrm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bbrm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = (r_state != bbrm_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### design/buddy_block_release_merge_top.sv
// top level of the buddy release and merge block
// Buddy-system release with coalescing over a pool of 1024 units (orders 0..10).
// A free bitmap per order sits in one 2048 x 1 single port ram. After reset the
// block sweeps the ram to zero, one entry per cycle; it takes no item during
// that sweep. A release item checks its own bit, then climbs the orders: each
// step reads the buddy bit and, if it is set, clears it and moves up one order;
// finally the merged block's bit is set. The single ram port sets the pace:
// each order climbed passes a buddy read state and a buddy check state. One
// item is in work at a time. The result sits in an output register, so the next
// item is taken while a result still waits to be drained.
// status: 0 ok, 1 misaligned or outside the pool, 2 block already free.
module buddy_block_release_merge_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bbrm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bbrm_pkg::t_out_item o_out_item
);

    // controller to datapath commands and returned status flags
    bbrm_pkg::t_dp_cmd  dp_cmd;
    bbrm_pkg::t_dp_stat dp_stat;

    bbrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // bitmap ram, cascade registers and the result register
    bbrm_datapath u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (i_in_item),
        .i_cmd  (dp_cmd),
        .o_stat (dp_stat),
        .o_item (o_out_item)
    );

endmodule

### sim/tb_buddy_block_release_merge_top.sv
// self-checking testbench for the buddy release and merge block
module tb_buddy_block_release_merge_top;
    import bbrm_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;  // covers the clearing sweep after reset
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int TAIL_CYCLES    = 40;    // settle time after the last result
    localparam int PHASE_ITEMS    = 350;

    typedef struct packed {
        t_in_item  item;
        logic      typed;   // expected result written into the row itself
        t_out_item want;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_item  i_in_item = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // side band that travels with the offered item
    logic      row_typed = 1'b0;
    t_out_item row_want = '0;

    // predictor state: one free bit per aligned block, orders stacked from 0
    bit        free_bits [MAP_BITS];
    t_out_item pending_results [$];

    int idle_pct = 0;
    int stall_pct = 0;
    logic hold_req = 1'b0;
    int hold_cnt = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int items_in = 0;
    int results_checked = 0;
    int n_released = 0;
    int n_queries = 0;
    int n_rejected = 0;
    int n_dup = 0;
    int deepest = 0;

    t_dir_row dir_rows [$];

    buddy_block_release_merge_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int bitmap_slot(input int k, input int b);
        return (MAP_BITS - (MAP_BITS >> k) + (b >> k)) & (MAP_BITS - 1);
    endfunction

    // release with buddy coalescing, or a lookup; updates the free bitmap
    function automatic t_out_item predict_release(input t_in_item it);
        t_out_item r;
        int        k;
        int        cur;
        int        mask;
        r.status      = ST_OK;
        r.final_order = it.order;
        r.final_base  = it.base;
        r.is_free     = 1'b0;
        mask = (1 << it.order) - 1;
        if (it.order > ORDERS || (int'(it.base) >> ORDERS) != 0 ||
            (int'(it.base) & mask) != 0) begin
            r.status = ST_BAD;
            n_rejected++;
        end else if (it.kind == KIND_QUERY) begin
            r.is_free = free_bits[bitmap_slot(it.order, it.base)];
            n_queries++;
        end else if (free_bits[bitmap_slot(it.order, it.base)]) begin
            r.status = ST_ALREADY;
            n_dup++;
        end else begin
            k   = it.order;
            cur = it.base;
            // climb while the buddy at this order is free
            while (k < ORDERS && free_bits[bitmap_slot(k, cur ^ (1 << k))]) begin
                free_bits[bitmap_slot(k, cur ^ (1 << k))] = 1'b0;
                cur = cur & ~(1 << k);
                k++;
            end
            free_bits[bitmap_slot(k, cur)] = 1'b1;
            r.final_order = ORDER_W'(k);
            r.final_base  = BASE_W'(cur);
            if (k - int'(it.order) > deepest)
                deepest = k - int'(it.order);
            n_released++;
        end
        return r;
    endfunction

    function automatic t_in_item make_item(input logic kind, input int ord, input int b);
        t_in_item it;
        it.kind  = kind;
        it.order = ORDER_W'(ord);
        it.base  = BASE_W'(b);
        return it;
    endfunction

    function automatic t_dir_row dir_row(input logic kind, input int ord, input int b,
                                         input logic typed, input logic [1:0] st,
                                         input int f_ord, input int f_base,
                                         input logic free);
        t_dir_row r;
        r.item              = make_item(kind, ord, b);
        r.typed             = typed;
        r.want.status       = st;
        r.want.final_order  = ORDER_W'(f_ord);
        r.want.final_base   = BASE_W'(f_base);
        r.want.is_free      = free;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // monitor: predicts on input acceptance, checks on output acceptance
    always @(posedge i_clk) begin
        t_out_item pred;
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                pred = predict_release(i_in_item);
                // a typed row still runs through the predictor to keep its bitmap
                pending_results.push_back(row_typed ? row_want : pred);
                items_in++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h",
                             $time, o_out_item);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, o_out_item.status);
                    check_field("final_order", want.final_order, o_out_item.final_order);
                    check_field("final_base", want.final_base, o_out_item.final_base);
                    check_field("is_free", want.is_free, o_out_item.is_free);
                    results_checked++;
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off counted here
    always @(posedge i_clk) begin
        if (hold_req && hold_cnt < HOLD_CYCLES) begin
            i_out_stall <= 1'b1;
            hold_cnt    <= hold_cnt + 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // offer one item after a random gap, return at the edge that takes it
    task automatic offer_item(input t_in_item it, input logic typed, input t_out_item want);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        row_typed  <= typed;
        row_want   <= want;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // sender pause until every expected result has been drained; one edge
    // first so the item taken at the current edge is already queued
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // random part: mostly a region chopped into aligned pieces released in
    // shuffled order, so the pieces coalesce back up; queries and junk mixed in
    task automatic run_random(input int count);
        t_in_item pieces [$];
        t_in_item split_q [$];
        t_in_item it;
        t_in_item last_rel;
        int       sent;
        int       r;
        int       region;
        int       j;
        int       roll;
        int       o;
        sent = 0;
        last_rel = make_item(KIND_RELEASE, 0, 0);
        while (sent < count) begin
            r = ($urandom_range(0, 99) < 15) ? ORDERS : $urandom_range(1, 7);
            region = $urandom_range(0, 1023) & ~((1 << r) - 1);
            pieces.delete();
            split_q.delete();
            split_q.push_back(make_item(KIND_RELEASE, r, region));
            while (split_q.size() != 0) begin
                it = split_q.pop_front();
                if (it.order != 0 && split_q.size() + pieces.size() < 48 &&
                    $urandom_range(0, 99) < 75) begin
                    split_q.push_back(make_item(KIND_RELEASE, it.order - 1, it.base));
                    split_q.push_back(make_item(KIND_RELEASE, it.order - 1,
                                                it.base + (1 << (it.order - 1))));
                end else begin
                    pieces.push_back(it);
                end
            end
            for (int i = pieces.size() - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                it = pieces[i];
                pieces[i] = pieces[j];
                pieces[j] = it;
            end
            for (int i = 0; i < pieces.size() && sent < count; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 18) begin
                    if (roll < 10) begin
                        o = $urandom_range(0, ORDERS);
                        it = make_item(KIND_QUERY, o,
                                       $urandom_range(0, 1023) & ~((1 << o) - 1));
                    end else if (roll < 15) begin
                        it = make_item(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                                       $urandom_range(0, 1023));
                    end else begin
                        it = last_rel;  // usually already free by now
                    end
                    offer_item(it, 1'b0, '0);
                    sent++;
                end
                offer_item(pieces[i], 1'b0, '0);
                last_rel = pieces[i];
                sent++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows: bad orders and bases, a short merge chain, the top
        // order, double release, overlap with a block already free higher up
        dir_rows.push_back(dir_row(KIND_QUERY,    0,    0, 1, ST_OK,      0,    0, 0));
        dir_rows.push_back(dir_row(KIND_QUERY,   10,    0, 1, ST_OK,     10,    0, 0));
        dir_rows.push_back(dir_row(KIND_RELEASE, 11,    0, 1, ST_BAD,    11,    0, 0));
        dir_rows.push_back(dir_row(KIND_RELEASE, 15, 1023, 1, ST_BAD,    15, 1023, 0));
        dir_rows.push_back(dir_row(KIND_RELEASE,  1,    1, 1, ST_BAD,     1,    1, 0));
        dir_rows.push_back(dir_row(KIND_QUERY,   12,    0, 1, ST_BAD,    12,    0, 0));
        dir_rows.push_back(dir_row(KIND_QUERY,    3,    4, 1, ST_BAD,     3,    4, 0));
        dir_rows.push_back(dir_row(KIND_RELEASE,  0, 1023, 1, ST_OK,      0, 1023, 0));
        dir_rows.push_back(dir_row(KIND_RELEASE,  0, 1023, 1, ST_ALREADY, 0, 1023, 0));
        dir_rows.push_back(dir_row(KIND_QUERY,    0, 1023, 1, ST_OK,      0, 1023, 1));
        dir_rows.push_back(dir_row(KIND_RELEASE,  0, 1022, 1, ST_OK,      1, 1022, 0));
        dir_rows.push_back(dir_row(KIND_QUERY,    0, 1023, 1, ST_OK,      0, 1023, 0));
        dir_rows.push_back(dir_row(KIND_RELEASE,  1, 1020, 1, ST_OK,      2, 1020, 0));
        dir_rows.push_back(dir_row(KIND_RELEASE, 10,    0, 1, ST_OK,     10,    0, 0));
        dir_rows.push_back(dir_row(KIND_RELEASE, 10,    0, 1, ST_ALREADY,10,    0, 0));
        dir_rows.push_back(dir_row(KIND_QUERY,   10,    0, 0, ST_OK,      0,    0, 0));
        dir_rows.push_back(dir_row(KIND_RELEASE,  9,  512, 0, ST_OK,      0,    0, 0));
        dir_rows.push_back(dir_row(KIND_RELEASE,  9,    0, 0, ST_OK,      0,    0, 0));
        dir_rows.push_back(dir_row(KIND_QUERY,    9,  512, 0, ST_OK,      0,    0, 0));
        dir_rows.push_back(dir_row(KIND_RELEASE,  0,    0, 0, ST_OK,      0,    0, 0));
        dir_rows.push_back(dir_row(KIND_RELEASE,  0,    1, 0, ST_OK,      0,    0, 0));
        dir_rows.push_back(dir_row(KIND_RELEASE,  1,    2, 0, ST_OK,      0,    0, 0));
        dir_rows.push_back(dir_row(KIND_QUERY,    2,    0, 0, ST_OK,      0,    0, 0));
        dir_rows.push_back(dir_row(KIND_QUERY,    2, 1020, 0, ST_OK,      0,    0, 0));

        // slow sender, busy receiver
        idle_pct  = 24;
        stall_pct = 82;
        foreach (dir_rows[i])
            offer_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        wait_drained();
        run_random(PHASE_ITEMS);
        wait_drained();

        // roles swapped
        idle_pct  = 82;
        stall_pct = 24;
        run_random(PHASE_ITEMS);
        wait_drained();

        // full rate; the receiver first holds off so the block backs up
        idle_pct  = 0;
        stall_pct = 0;
        hold_req <= 1'b1;
        run_random(PHASE_ITEMS);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0)
            mismatches++;
        $display("ran %0d items: %0d releases merged, %0d queries, %0d rejected, %0d dup",
                 items_in, n_released, n_queries, n_rejected, n_dup);
        $display("checked %0d results, longest merge climbed %0d orders",
                 results_checked, deepest);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
